FILE: src/step_direction_counter_with_rate_core_defines.svh
// Assertion macros shared by the step/direction counter modules.
`ifndef STEP_DIRECTION_COUNTER_WITH_RATE_CORE_DEFINES_SVH
`define STEP_DIRECTION_COUNTER_WITH_RATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SDCR_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SDCR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SDCR_ASSERT_SAME(name, clk, rst, ante, cons)
`define SDCR_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: src/sdcr_pkg.sv
package sdcr_pkg;

   localparam int POS_W     = 64;
   localparam int TICKS_W   = 32;
   localparam int STAMP_W   = 32;
   localparam int DIV_STEPS = TICKS_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [TICKS_W-1:0] TICKS_RESET = 32'd1000000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_step;
      logic out_free;
   } status_type;

endpackage

FILE: src/step_direction_counter_with_rate_core.sv
// After a request word is accepted, the 32-step restoring divider runs; the result then
// moves to the output register once that register is free, and rsp_tvalid rises.
// No new request word is taken while the divider is still busy with the previous one.
// A new request is taken while the previous response still waits in the output register.
// Reset (synchronous, active high) clears positions and last edge times to zero,
// sets ticks_per_second to 1000000 and empties the output register.
`include "step_direction_counter_with_rate_core_defines.svh"

module step_direction_counter_with_rate_core #(
   parameter int CHANNELS   = 2,
   parameter int TIME_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,   // ticks_per_second
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,     // direction [0], timestamp_us [32:1], zero pad
   input  logic         req_tuser,     // channel [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,     // position [63:0], frequency [95:64]
   output logic         rsp_tuser      // zero_interval [0]
);
   import sdcr_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [POS_W-1:0]   position;
   logic [TICKS_W-1:0] frequency;

   sdcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sdcr_datapath #(
      .CHANNELS   (CHANNELS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_channel   (req_tuser),
      .req_direction (req_tdata[0]),
      .req_timestamp (req_tdata[32:1]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_position  (position),
      .rsp_frequency (frequency),
      .rsp_zero      (rsp_tuser)
   );

   assign rsp_tdata = {frequency, position};

   `SDCR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

FILE: src/sdcr_ctrl.sv
`include "step_direction_counter_with_rate_core_defines.svh"

module sdcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sdcr_pkg::status_type status,
   output sdcr_pkg::cmd_type    cmd
);
   import sdcr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold the finished quotient until the output register frees up.
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SDCR_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_tvalid && req_tready, state_ff == ST_DIV)
   `SDCR_ASSERT_SAME(a_cmd_exclusive, clock, reset, 1'b1, $onehot0({cmd.load, cmd.step, cmd.emit}))
   `SDCR_ASSERT_SAME(a_emit_needs_room, clock, reset, cmd.emit, status.out_free)

endmodule

FILE: src/sdcr_datapath.sv
`include "step_direction_counter_with_rate_core_defines.svh"

module sdcr_datapath #(
   parameter int CHANNELS   = 2,
   parameter int TIME_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sdcr_pkg::cmd_type              cmd,
   output sdcr_pkg::status_type           status,
   input  logic                           csr_wr_en,
   input  logic [sdcr_pkg::TICKS_W-1:0]   csr_wr_data,
   input  logic                           req_channel,
   input  logic                           req_direction,
   input  logic [sdcr_pkg::STAMP_W-1:0]   req_timestamp,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sdcr_pkg::POS_W-1:0]     rsp_position,
   output logic [sdcr_pkg::TICKS_W-1:0]   rsp_frequency,
   output logic                           rsp_zero
);
   import sdcr_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   // Remainder must hold both a full numerator prefix and any divisor.
   localparam int REM_W = (TIME_WIDTH > TICKS_W) ? TIME_WIDTH : TICKS_W;
   localparam int SH_W  = REM_W + 1;

   logic [TICKS_W-1:0]    ticks_ff;
   logic [POS_W-1:0]      pos_ff   [CHANNELS];
   logic [TIME_WIDTH-1:0] last_ff  [CHANNELS];

   logic [TIME_WIDTH-1:0] divisor_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [REM_W-1:0]      rem_in;
   logic [TICKS_W-1:0]    quot_ff;
   logic [TICKS_W-1:0]    quot_in;
   logic [STEP_W-1:0]     cnt_ff;
   logic [POS_W-1:0]      res_pos_ff;
   logic                  zero_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [TICKS_W-1:0]    rsp_freq_ff;
   logic                  rsp_zero_ff;

   logic [CH_W-1:0]       idx;
   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] interval;
   logic [POS_W-1:0]      pos_new;
   logic [SH_W-1:0]       rem_sh;
   logic [SH_W-1:0]       rem_diff;

   always_comb begin
      if (int'(req_channel) >= CHANNELS) begin
         idx = CH_W'(CHANNELS - 1);
      end else begin
         idx = CH_W'(req_channel);
      end
      now      = TIME_WIDTH'(req_timestamp);
      interval = now - last_ff[idx];
      pos_new  = req_direction ? pos_ff[idx] + POS_W'(1) : pos_ff[idx] - POS_W'(1);
   end

   // One restoring division step per cycle, quotient bits shift in at the bottom.
   always_comb begin
      rem_sh   = {rem_ff, quot_ff[TICKS_W-1]};
      rem_diff = rem_sh - SH_W'(divisor_ff);
      if (rem_sh >= SH_W'(divisor_ff)) begin
         rem_in  = rem_diff[REM_W-1:0];
         quot_in = {quot_ff[TICKS_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh[REM_W-1:0];
         quot_in = {quot_ff[TICKS_W-2:0], 1'b0};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.last_step = (cnt_ff == STEP_W'(DIV_STEPS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= TICKS_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i]  <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ticks_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            pos_ff[idx]  <= pos_new;
            last_ff[idx] <= now;
            cnt_ff       <= '0;
         end else if (cmd.step) begin
            cnt_ff <= cnt_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         divisor_ff <= interval;
         rem_ff     <= '0;
         quot_ff    <= ticks_ff;
         res_pos_ff <= pos_new;
         zero_ff    <= (interval == '0);
      end else if (cmd.step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (cmd.emit) begin
         rsp_pos_ff  <= res_pos_ff;
         rsp_freq_ff <= zero_ff ? ticks_ff : quot_ff;
         rsp_zero_ff <= zero_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_frequency = rsp_freq_ff;
   assign rsp_zero      = rsp_zero_ff;

   `SDCR_ASSERT_NEXT(a_emit_sets_valid, clock, reset, cmd.emit, rsp_valid_ff)
   `SDCR_ASSERT_NEXT(a_load_clears_count, clock, reset, cmd.load, cnt_ff == '0)
   `SDCR_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.emit && rsp_valid_ff, rsp_tready)

endmodule
